### hw/rtl/binned_stream_signature_filter_macros.svh
// Assertion macros used by the checker file of the signature filter.
`ifndef BINNED_STREAM_SIGNATURE_FILTER_MACROS_SVH
`define BINNED_STREAM_SIGNATURE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSSF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/bssf_pkg.sv
// Types, constants and the hash step function of the signature filter.
package bssf_pkg;

   typedef enum logic {
      REQ_DATA   = 1'b0,
      REQ_REPORT = 1'b1
   } req_kind_type;

   localparam int ION_TAB_LEN   = 8;
   localparam int SHELL_TAB_LEN = 4;
   localparam int ION_SLOT_W    = 3;
   localparam int SHELL_SLOT_W  = 2;

   localparam logic [6:0] ION_Z_TAB [ION_TAB_LEN] =
      '{7'd14, 7'd14, 7'd16, 7'd16, 7'd26, 7'd26, 7'd26, 7'd27};
   localparam logic [4:0] ION_STAGE_TAB [ION_TAB_LEN] =
      '{5'd1, 5'd2, 5'd1, 5'd2, 5'd1, 5'd2, 5'd3, 5'd2};
   localparam logic [7:0] SHELL_TAB [SHELL_TAB_LEN] =
      '{8'd0, 8'd8, 8'd43, 8'd49};

   localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
   // Prime is 2^40 + 0x1B3.
   localparam int          FNV_SHIFT    = 40;
   localparam logic [63:0] FNV_PRIME_LO = 64'h1B3;
   localparam int          HASH_STEPS   = 8;
   localparam int          STEP_W       = $clog2(HASH_STEPS);

   localparam logic [26:0] ID_LIMIT  = 27'd100000000;
   localparam logic [47:0] TALLY_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] count;
      logic [63:0] hash;
      logic [63:0] sum;
      logic [26:0] first;
      logic [26:0] last;
      logic        rising;
   } bin_rec_type;

   localparam int BIN_REC_W = $bits(bin_rec_type);

   localparam bin_rec_type BIN_RESET = '{
      count:  32'd0,
      hash:   FNV_BASIS,
      sum:    64'd0,
      first:  27'd0,
      last:   27'd0,
      rising: 1'b0
   };

   typedef struct packed {
      logic        load;
      logic [63:0] basis;
      logic [26:0] id;
   } fnv_ctl_type;

   typedef struct packed {
      logic        done;
      logic [63:0] hash;
   } fnv_stat_type;

   // One FNV-1a round: fold in a byte, multiply by the prime as shift plus small product.
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << FNV_SHIFT) + (x * FNV_PRIME_LO);
   endfunction

endpackage

### hw/rtl/binned_stream_signature_filter.sv
// Signature filter top level: sequencer, bin store, tallies and result registers.
//
//  channel | ports                            | handshake
//  --------+----------------------------------+-----------------------------------
//  request | start, busy, req_*               | taken at an edge with start & !busy
//  result  | rsp_valid, rsp_*                 | one-cycle strobe, cannot be held off
//  config  | csr_wr_en, csr_wr_data           | written at an edge with csr_wr_en
//
// Steps per word: a row that is dropped or malformed is answered from decode; a
// report reads the bin RAM twice, sentinel bin second, then compares; a row that
// updates a bin takes a RAM read, stats update, 8 rounds of the hash unit, write back.
// The result strobe falls in the first idle cycle, so the next word may start there.
// Reset is synchronous; per-bin valid bits make every bin read as empty after reset,
// with no clearing pass. There is no backpressure on results.
module binned_stream_signature_filter #(
   parameter int NUM_IONS   = 8,
   parameter int NUM_SHELLS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [15:0] req_iteration,
   input  logic [7:0]  req_shell_id,
   input  logic [6:0]  req_atomic_number,
   input  logic [4:0]  req_ionization_stage,
   input  logic [26:0] req_line_id,
   input  logic        req_parse_error,
   input  logic [1:0]  req_report_shell_slot,
   input  logic [2:0]  req_report_ion_slot,
   output logic        rsp_valid,
   output logic        rsp_keep_row,
   output logic        rsp_row_malformed,
   output logic [31:0] rsp_sig_count,
   output logic [26:0] rsp_sig_first,
   output logic [26:0] rsp_sig_last,
   output logic [63:0] rsp_sig_sum,
   output logic [63:0] rsp_sig_hash,
   output logic        rsp_sig_increasing,
   output logic        rsp_sig_matches,
   output logic [47:0] rsp_malformed_total,
   output logic [47:0] rsp_selected_total,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import bssf_pkg::*;

   localparam int NUM_BINS = NUM_SHELLS * NUM_IONS;
   localparam int BIN_W    = $clog2(NUM_BINS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_CMP,
      S_HASH
   } state_type;

   state_type state_ff;

   logic [15:0] target_iter_ff;

   // Captured request word.
   req_kind_type req_type_ff;
   logic [15:0]  iter_ff;
   logic [7:0]   shell_ff;
   logic [6:0]   z_ff;
   logic [4:0]   stage_ff;
   logic [26:0]  id_ff;
   logic         perr_ff;
   logic [1:0]   rss_ff;
   logic [2:0]   rqi_ff;

   logic [SHELL_SLOT_W-1:0] shell_idx_ff;
   logic [BIN_W-1:0]        addr_ff;
   logic [NUM_BINS-1:0]     bin_valid_ff;
   bin_rec_type             work_ff;
   bin_rec_type             cur_ff;
   logic [47:0]             malformed_tally_ff;
   logic [47:0]             kept_tally_ff;

   logic        rsp_valid_ff;
   logic        rsp_keep_row_ff;
   logic        rsp_row_malformed_ff;
   logic [31:0] rsp_sig_count_ff;
   logic [26:0] rsp_sig_first_ff;
   logic [26:0] rsp_sig_last_ff;
   logic [63:0] rsp_sig_sum_ff;
   logic [63:0] rsp_sig_hash_ff;
   logic        rsp_sig_increasing_ff;
   logic        rsp_sig_matches_ff;

   logic                    ion_hit;
   logic [ION_SLOT_W-1:0]   ion_idx;
   logic                    shell_hit;
   logic [SHELL_SLOT_W-1:0] shell_idx;
   logic                    row_sel;
   logic                    id_bad;
   logic                    row_bad;
   logic                    data_go;
   logic                    rpt_go;
   logic [BIN_W-1:0]        data_bin;
   logic [BIN_W-1:0]        rpt_bin;
   logic [BIN_W-1:0]        sent_bin;
   bin_rec_type             rec_rd;
   bin_rec_type             rec_upd;
   logic                    bins_match;
   logic                    to_sentinel;
   logic [47:0]             malformed_inc;
   logic [47:0]             kept_inc;

   logic                 ram_wr_en;
   bin_rec_type          ram_wr_rec;
   logic                 ram_rd_en;
   logic [BIN_W-1:0]     ram_rd_addr;
   logic [BIN_REC_W-1:0] ram_rd_data;

   fnv_ctl_type  fnv_ctl;
   fnv_stat_type fnv_stat;

   // Table lookups; lowest matching slot wins.
   always_comb begin
      ion_hit   = 1'b0;
      ion_idx   = '0;
      shell_hit = 1'b0;
      shell_idx = '0;
      for (int i = ION_TAB_LEN - 1; i >= 0; i--) begin
         if (i < NUM_IONS && ION_Z_TAB[i] == z_ff && ION_STAGE_TAB[i] == stage_ff) begin
            ion_hit = 1'b1;
            ion_idx = ION_SLOT_W'(i);
         end
      end
      for (int i = SHELL_TAB_LEN - 1; i >= 0; i--) begin
         if (i < NUM_SHELLS && SHELL_TAB[i] == shell_ff) begin
            shell_hit = 1'b1;
            shell_idx = SHELL_SLOT_W'(i);
         end
      end
   end

   assign row_sel  = !perr_ff && (iter_ff == target_iter_ff) && shell_hit && ion_hit;
   assign id_bad   = id_ff > ID_LIMIT;
   assign row_bad  = (req_type_ff == REQ_DATA) && (perr_ff || (row_sel && id_bad));
   assign data_go  = (req_type_ff == REQ_DATA) && row_sel && !id_bad;
   assign rpt_go   = (req_type_ff == REQ_REPORT) && (int'(rss_ff) < NUM_SHELLS) &&
                     (int'(rqi_ff) < NUM_IONS);
   assign data_bin = BIN_W'(int'(shell_idx) * NUM_IONS + int'(ion_idx));
   assign rpt_bin  = BIN_W'(int'(rss_ff) * NUM_IONS + int'(rqi_ff));
   assign sent_bin = BIN_W'((NUM_SHELLS - 1) * NUM_IONS + int'(rqi_ff));

   assign to_sentinel = !(int'(shell_idx_ff) < NUM_SHELLS - 1);

   assign malformed_inc = (malformed_tally_ff == TALLY_MAX) ? TALLY_MAX :
                          malformed_tally_ff + 48'd1;
   assign kept_inc      = (kept_tally_ff == TALLY_MAX) ? TALLY_MAX : kept_tally_ff + 48'd1;

   // A bin never written reads as its reset value.
   assign rec_rd = bin_valid_ff[addr_ff] ? bin_rec_type'(ram_rd_data) : BIN_RESET;

   always_comb begin
      rec_upd = rec_rd;
      if (rec_rd.count == 32'd0) begin
         rec_upd.first  = id_ff;
         rec_upd.rising = 1'b1;
      end else if (id_ff <= rec_rd.last) begin
         rec_upd.rising = 1'b0;
      end
      rec_upd.last = id_ff;
      if (rec_rd.count != COUNT_MAX) begin
         rec_upd.count = rec_rd.count + 32'd1;
      end
      rec_upd.sum = rec_rd.sum + {37'd0, id_ff};
   end

   // cur_ff is the reported bin, rec_rd the sentinel bin in S_CMP.
   always_comb begin
      if (cur_ff.count == 32'd0 && rec_rd.count == 32'd0) begin
         bins_match = 1'b1;
      end else begin
         bins_match = (cur_ff.count == rec_rd.count) && (cur_ff.hash == rec_rd.hash) &&
                      (cur_ff.sum == rec_rd.sum) && (cur_ff.first == rec_rd.first) &&
                      (cur_ff.last == rec_rd.last) && cur_ff.rising && rec_rd.rising;
      end
   end

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = data_bin;
      case (state_ff)
         S_DECODE: begin
            ram_rd_en   = data_go || rpt_go;
            ram_rd_addr = (req_type_ff == REQ_REPORT) ? rpt_bin : data_bin;
         end
         S_LOAD: begin
            ram_rd_en   = (req_type_ff == REQ_REPORT);
            ram_rd_addr = sent_bin;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   assign ram_wr_en       = (state_ff == S_HASH) && fnv_stat.done;
   always_comb begin
      ram_wr_rec      = work_ff;
      ram_wr_rec.hash = fnv_stat.hash;
   end

   assign fnv_ctl.load  = (state_ff == S_LOAD) && (req_type_ff == REQ_DATA);
   assign fnv_ctl.basis = rec_rd.hash;
   assign fnv_ctl.id    = id_ff;

   bssf_ram #(
      .WIDTH (BIN_REC_W),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_rec),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bssf_fnv u_fnv (
      .clock (clock),
      .reset (reset),
      .ctl   (fnv_ctl),
      .stat  (fnv_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         target_iter_ff <= 16'd0;
      end else if (csr_wr_en) begin
         target_iter_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         rsp_valid_ff       <= 1'b0;
         bin_valid_ff       <= '0;
         malformed_tally_ff <= 48'd0;
         kept_tally_ff      <= 48'd0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_type_ff <= req_kind_type'(req_type);
                  iter_ff     <= req_iteration;
                  shell_ff    <= req_shell_id;
                  z_ff        <= req_atomic_number;
                  stage_ff    <= req_ionization_stage;
                  id_ff       <= req_line_id;
                  perr_ff     <= req_parse_error;
                  rss_ff      <= req_report_shell_slot;
                  rqi_ff      <= req_report_ion_slot;
                  state_ff    <= S_DECODE;
               end
            end
            S_DECODE: begin
               shell_idx_ff <= shell_idx;
               addr_ff      <= (req_type_ff == REQ_REPORT) ? rpt_bin : data_bin;
               if (data_go || rpt_go) begin
                  state_ff <= S_LOAD;
               end else begin
                  // Drop, malformed or out-of-range report: answer now with zero stats.
                  rsp_valid_ff          <= 1'b1;
                  rsp_keep_row_ff       <= 1'b0;
                  rsp_row_malformed_ff  <= row_bad;
                  rsp_sig_count_ff      <= 32'd0;
                  rsp_sig_first_ff      <= 27'd0;
                  rsp_sig_last_ff       <= 27'd0;
                  rsp_sig_sum_ff        <= 64'd0;
                  rsp_sig_hash_ff       <= 64'd0;
                  rsp_sig_increasing_ff <= 1'b0;
                  rsp_sig_matches_ff    <= 1'b0;
                  if (row_bad) begin
                     malformed_tally_ff <= malformed_inc;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_LOAD: begin
               if (req_type_ff == REQ_REPORT) begin
                  cur_ff   <= rec_rd;
                  addr_ff  <= sent_bin;
                  state_ff <= S_CMP;
               end else begin
                  work_ff  <= rec_upd;
                  state_ff <= S_HASH;
               end
            end
            S_CMP: begin
               rsp_valid_ff          <= 1'b1;
               rsp_keep_row_ff       <= 1'b0;
               rsp_row_malformed_ff  <= 1'b0;
               rsp_sig_count_ff      <= cur_ff.count;
               rsp_sig_first_ff      <= cur_ff.first;
               rsp_sig_last_ff       <= cur_ff.last;
               rsp_sig_sum_ff        <= cur_ff.sum;
               rsp_sig_hash_ff       <= cur_ff.hash;
               rsp_sig_increasing_ff <= cur_ff.rising;
               rsp_sig_matches_ff    <= bins_match;
               state_ff              <= S_IDLE;
            end
            S_HASH: begin
               if (fnv_stat.done) begin
                  bin_valid_ff[addr_ff] <= 1'b1;
                  rsp_valid_ff          <= 1'b1;
                  rsp_keep_row_ff       <= !to_sentinel;
                  rsp_row_malformed_ff  <= 1'b0;
                  rsp_sig_count_ff      <= 32'd0;
                  rsp_sig_first_ff      <= 27'd0;
                  rsp_sig_last_ff       <= 27'd0;
                  rsp_sig_sum_ff        <= 64'd0;
                  rsp_sig_hash_ff       <= 64'd0;
                  rsp_sig_increasing_ff <= 1'b0;
                  rsp_sig_matches_ff    <= 1'b0;
                  // Sentinel-shell rows update their bin but are not forwarded.
                  if (!to_sentinel) begin
                     kept_tally_ff <= kept_inc;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_keep_row        = rsp_keep_row_ff;
   assign rsp_row_malformed   = rsp_row_malformed_ff;
   assign rsp_sig_count       = rsp_sig_count_ff;
   assign rsp_sig_first       = rsp_sig_first_ff;
   assign rsp_sig_last        = rsp_sig_last_ff;
   assign rsp_sig_sum         = rsp_sig_sum_ff;
   assign rsp_sig_hash        = rsp_sig_hash_ff;
   assign rsp_sig_increasing  = rsp_sig_increasing_ff;
   assign rsp_sig_matches     = rsp_sig_matches_ff;
   assign rsp_malformed_total = malformed_tally_ff;
   assign rsp_selected_total  = kept_tally_ff;

endmodule

### hw/rtl/bssf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bssf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bssf_fnv.sv
// Iterative FNV-1a-64 unit: one byte of the id per cycle, lowest byte first.
module bssf_fnv (
   input  logic                  clock,
   input  logic                  reset,
   input  bssf_pkg::fnv_ctl_type ctl,
   output bssf_pkg::fnv_stat_type stat
);
   import bssf_pkg::*;

   logic [63:0]       hash_ff;
   logic [31:0]       byte_sr_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.load) begin
            hash_ff    <= ctl.basis;
            byte_sr_ff <= {5'd0, ctl.id};
            step_ff    <= '0;
            run_ff     <= 1'b1;
         end else if (run_ff) begin
            // Upper bytes of the id are zero once the shifter empties.
            hash_ff    <= fnv_step(hash_ff, byte_sr_ff[7:0]);
            byte_sr_ff <= byte_sr_ff >> 8;
            step_ff    <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(HASH_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.done = done_ff;
   assign stat.hash = hash_ff;

endmodule

### hw/rtl/bssf_checker.sv
// Port-level checker for the signature filter and its bind to the top level.
`include "binned_stream_signature_filter_macros.svh"

module bssf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_keep_row,
   input logic        rsp_row_malformed,
   input logic [31:0] rsp_sig_count,
   input logic        rsp_sig_matches
);

   // An accepted word keeps the block busy for at least the next cycle.
   `BSSF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // A result appears only as the block returns to idle.
   `BSSF_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy, "result while busy")

   // The result strobe lasts a single cycle.
   `BSSF_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid, "result strobe held")

   // A row is either forwarded or malformed, never both.
   `BSSF_ASSERT_NOW(a_keep_xor_bad, clock, reset, rsp_valid,
      !(rsp_keep_row && rsp_row_malformed), "row both kept and malformed")

   // Row results carry no bin statistics.
   `BSSF_ASSERT_NOW(a_row_no_stats, clock, reset,
      rsp_valid && (rsp_keep_row || rsp_row_malformed),
      rsp_sig_count == 32'd0 && !rsp_sig_matches, "row result with bin stats")

endmodule

bind binned_stream_signature_filter bssf_checker u_bssf_checker (.*);
